// ----- rtl/interval_timer_register_interface_assert.svh -----
// Assertion macros shared by the interval timer checker.
`ifndef INTERVAL_TIMER_REGISTER_INTERFACE_ASSERT_SVH
`define INTERVAL_TIMER_REGISTER_INTERFACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ITI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ITI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/iti_pkg.sv -----
// Types and fixed constants of the interval timer register interface.
`default_nettype none

package iti_pkg;

  // Channel register slots that exist in hardware.
  localparam int unsigned CHAN_SLOTS = 3;
  localparam int unsigned CH_IDX_W   = $clog2(CHAN_SLOTS);

  // Port offsets and request codes.
  localparam logic [1:0] PORT_CMD  = 2'd3;
  localparam logic       REQ_WRITE = 1'b1;

  // Command word fields: channel select of three means read-back.
  localparam logic [1:0] CMD_READBACK = 2'd3;
  localparam logic [1:0] ACC_LATCH    = 2'd0;
  localparam logic [1:0] ACC_HIGH     = 2'd2;
  localparam logic [1:0] ACC_BOTH     = 2'd3;

  // Reload count arithmetic.
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned PROD_W  = 36;
  localparam int unsigned USEC_PER_SEC   = 1000000;
  localparam int unsigned MILLI_PER_UNIT = 1000;
  localparam int unsigned BCD_THOUSANDS  = 1000;
  localparam int unsigned BCD_HUNDREDS   = 100;
  localparam int unsigned BCD_TENS       = 10;
  localparam logic [COUNT_W-1:0] BCD_ZERO_COUNT = 17'd10000;
  localparam logic [COUNT_W-1:0] BIN_ZERO_COUNT = 17'd65536;

  // Result field widths and saturation limits.
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned FREQ_W   = 32;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX   = '1;

  // Outcome of one bus access, as decoded against the channel registers.
  typedef struct packed {
    logic [7:0]          read_data;
    logic                timing_valid;
    logic [1:0]          timing_channel;
    logic                channel_enabled;
    logic [7:0]          count_hi;
    logic [7:0]          count_lo;
    logic                bcd;
  } iti_access_t;

endpackage

`default_nettype wire

// ----- rtl/iti_ifs.sv -----
// Valid/ready channel interfaces for bus accesses and their results.
`default_nettype none

interface iti_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] port;
  logic [7:0] write_data;

  modport source (output valid, output req_type, output port, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input port, input write_data,
                output ready);
endinterface

interface iti_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        timing_valid;
  logic [1:0]  timing_channel;
  logic [23:0] period_us;
  logic [31:0] freq_millihertz;
  logic        channel_enabled;

  modport source (output valid, output read_data, output timing_valid,
                  output timing_channel, output period_us, output freq_millihertz,
                  output channel_enabled, input ready);
  modport sink (input valid, input read_data, input timing_valid,
                input timing_channel, input period_us, input freq_millihertz,
                input channel_enabled, output ready);
endinterface

`default_nettype wire

// ----- rtl/iti_regs.sv -----
// Channel register file with command decode, read-back and byte sequencing.
`default_nettype none

module iti_regs import iti_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc_en,
  input  logic        req_type,
  input  logic [1:0]  port,
  input  logic [7:0]  write_data,
  output iti_access_t access
);

  logic [7:0]            lo_r   [CHAN_SLOTS];
  logic [7:0]            lo_nxt [CHAN_SLOTS];
  logic [7:0]            hi_r   [CHAN_SLOTS];
  logic [7:0]            hi_nxt [CHAN_SLOTS];
  logic [5:0]            ctrl_r [CHAN_SLOTS];
  logic [5:0]            ctrl_nxt [CHAN_SLOTS];
  logic [CHAN_SLOTS-1:0] bcd_r, bcd_nxt;
  logic [CHAN_SLOTS-1:0] sel_r, sel_nxt;
  logic [CHAN_SLOTS-1:0] alt_r, alt_nxt;
  logic [CHAN_SLOTS-1:0] stat_r, stat_nxt;
  logic [CHAN_SLOTS-1:0] en_r, en_nxt;
  logic [1:0]            cmd_ch;
  logic [1:0]            cmd_acc;
  logic [CH_IDX_W-1:0]   cmd_idx;
  logic [CH_IDX_W-1:0]   port_idx;

  assign cmd_ch   = write_data[7:6];
  assign cmd_acc  = write_data[5:4];
  assign cmd_idx  = CH_IDX_W'(cmd_ch);
  assign port_idx = CH_IDX_W'(port);

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    ctrl_nxt = ctrl_r;
    bcd_nxt  = bcd_r;
    sel_nxt  = sel_r;
    alt_nxt  = alt_r;
    stat_nxt = stat_r;
    en_nxt   = en_r;
    access   = '0;
    if (port == PORT_CMD) begin
      if (req_type == REQ_WRITE) begin
        if (cmd_ch == CMD_READBACK) begin
          // Status is armed only when the channel bit is set and status is not masked.
          for (int n = 0; n < CHAN_SLOTS; n++) begin
            if (n < NUM_TIMERS) begin
              stat_nxt[n] = write_data[n+1] & ~write_data[4];
            end
          end
        end else if ((cmd_ch < NUM_TIMERS) && (cmd_acc != ACC_LATCH)) begin
          lo_nxt[cmd_idx]   = '0;
          hi_nxt[cmd_idx]   = '0;
          ctrl_nxt[cmd_idx] = write_data[5:0];
          bcd_nxt[cmd_idx]  = write_data[0];
          sel_nxt[cmd_idx]  = (cmd_acc == ACC_HIGH);
          alt_nxt[cmd_idx]  = (cmd_acc == ACC_BOTH);
          stat_nxt[cmd_idx] = 1'b0;
          en_nxt[cmd_idx]   = 1'b0;
        end
      end
    end else if (port < NUM_TIMERS) begin
      if (req_type == REQ_WRITE) begin
        if (sel_r[port_idx]) begin
          hi_nxt[port_idx] = write_data;
        end else begin
          lo_nxt[port_idx] = write_data;
        end
        sel_nxt[port_idx]     = sel_r[port_idx] ^ alt_r[port_idx];
        en_nxt[port_idx]      = 1'b1;
        access.timing_valid   = 1'b1;
        access.timing_channel = port;
        access.count_hi       = hi_nxt[port_idx];
        access.count_lo       = lo_nxt[port_idx];
        access.bcd            = bcd_r[port_idx];
      end else if (stat_r[port_idx]) begin
        stat_nxt[port_idx] = 1'b0;
        access.read_data   = {2'b00, ctrl_r[port_idx]};
      end else begin
        access.read_data  = sel_r[port_idx] ? hi_r[port_idx] : lo_r[port_idx];
        sel_nxt[port_idx] = sel_r[port_idx] ^ alt_r[port_idx];
      end
      access.channel_enabled = en_nxt[port_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '{default: '0};
      hi_r   <= '{default: '0};
      ctrl_r <= '{default: '0};
      bcd_r  <= '0;
      sel_r  <= '0;
      alt_r  <= '0;
      stat_r <= '0;
      en_r   <= '0;
    end else if (acc_en) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      ctrl_r <= ctrl_nxt;
      bcd_r  <= bcd_nxt;
      sel_r  <= sel_nxt;
      alt_r  <= alt_nxt;
      stat_r <= stat_nxt;
      en_r   <= en_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iti_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module iti_div import iti_pkg::*; #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // The numerator shifts out at the top while quotient bits shift in at the bottom.
  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign fits    = (trial >= {1'b0, den_r});
  assign rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign num_nxt = {num_r[NUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

`default_nettype wire

// ----- rtl/interval_timer_register_interface.sv -----
// Top level of the interval timer register interface.
//
// One bus access enters per transfer on in_bus: req_type selects read or write,
// port selects channel data ports zero to two or the command register at three.
// Every access yields exactly one result transfer on out_bus, in order.
// Reads and command writes are decoded against the channel registers at the
// accepting edge; the result is loaded into the output register from S_DONE
// once that register is free. A data write also reports period and frequency:
// the count is converted in S_CONV and multiplied in S_MUL, then two bit-serial
// dividers run side by side from S_START, one quotient bit per cycle, over the
// 36 numerator bits for the period and the bits of clock * 1000 for the
// frequency (31 at the default 1193182 Hz). The longer divider sets when the
// result is ready: the sequencer waits in S_WAIT until both dividers are done
// and then passes through S_DONE. One access is in work at a time;
// in_bus.ready is high only when the control sequencer is idle. The result sits
// in an output register, so the next access may be accepted while an earlier
// result still waits. When the receiver stalls, the result holds steady and a
// finished access waits for the output register before the sequencer goes idle.
// Synchronous reset clears all channel registers, empties the output register
// and returns the sequencer to idle; nothing is accepted while reset is held.
`default_nettype none

module interval_timer_register_interface import iti_pkg::*; #(
  parameter int unsigned NUM_TIMERS     = 3,
  parameter int unsigned INPUT_CLOCK_HZ = 1193182
) (
  input  logic      clk,
  input  logic      rst_n,
  iti_in_if.sink    in_bus,
  iti_out_if.source out_bus
);

  // Constant numerator of the frequency division and the widths it implies.
  localparam longint unsigned FREQ_NUM = 64'(INPUT_CLOCK_HZ) * 64'(MILLI_PER_UNIT);
  localparam int unsigned FNUM_W = $clog2(FREQ_NUM + 64'd1);
  localparam int unsigned CLK_W  = $clog2(64'(INPUT_CLOCK_HZ) + 64'd1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic                in_acc;
  logic                out_load;
  iti_access_t         access;
  iti_access_t         acc_r;
  logic [COUNT_W-1:0]  conv;
  logic [COUNT_W-1:0]  count_nxt;
  logic [COUNT_W-1:0]  count_r;
  logic [PROD_W-1:0]   prod_r;
  logic                div_start;
  logic                per_busy;
  logic                frq_busy;
  logic [PROD_W-1:0]   per_q;
  logic [FNUM_W-1:0]   frq_q;
  logic [PERIOD_W-1:0] period_sat;
  logic [FREQ_W-1:0]   freq_sat;

  logic                out_valid_r;
  logic [7:0]          read_data_r;
  logic                timing_valid_r;
  logic [1:0]          timing_channel_r;
  logic [PERIOD_W-1:0] period_r;
  logic [FREQ_W-1:0]   freq_r;
  logic                enabled_r;

  // A transfer is taken only by the idle sequencer and never during reset.
  assign in_bus.ready = rst_n && (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Channel registers are updated at the accepting edge; the decoded outcome
  // of the access is captured alongside.
  iti_regs #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_en     (in_acc),
    .req_type   (in_bus.req_type),
    .port       (in_bus.port),
    .write_data (in_bus.write_data),
    .access     (access)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r <= access;
    end
  end

  // Reload count: binary, or four decimal digits in BCD mode. Nibbles above
  // nine keep their face value. A zero count stands for the full range.
  always_comb begin
    if (acc_r.bcd) begin
      conv = COUNT_W'(acc_r.count_hi[7:4]) * COUNT_W'(BCD_THOUSANDS)
           + COUNT_W'(acc_r.count_hi[3:0]) * COUNT_W'(BCD_HUNDREDS)
           + COUNT_W'(acc_r.count_lo[7:4]) * COUNT_W'(BCD_TENS)
           + COUNT_W'(acc_r.count_lo[3:0]);
    end else begin
      conv = COUNT_W'({acc_r.count_hi, acc_r.count_lo});
    end
    if (conv == '0) begin
      count_nxt = acc_r.bcd ? BCD_ZERO_COUNT : BIN_ZERO_COUNT;
    end else begin
      count_nxt = conv;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CONV) begin
      count_r <= count_nxt;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(count_r) * PROD_W'(USEC_PER_SEC);
    end
  end

  assign div_start = (state_r == S_START);

  // Period: count * 1e6 / clock. Frequency: clock * 1000 / count.
  iti_div #(
    .NUM_W (PROD_W),
    .DEN_W (CLK_W)
  ) u_per_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (prod_r),
    .denom (CLK_W'(INPUT_CLOCK_HZ)),
    .busy  (per_busy),
    .quot  (per_q)
  );

  iti_div #(
    .NUM_W (FNUM_W),
    .DEN_W (COUNT_W)
  ) u_frq_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (FNUM_W'(FREQ_NUM)),
    .denom (count_r),
    .busy  (frq_busy),
    .quot  (frq_q)
  );

  assign period_sat = (64'(per_q) > 64'(PERIOD_MAX)) ? PERIOD_MAX : PERIOD_W'(per_q);
  assign freq_sat   = (64'(frq_q) > 64'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(frq_q);

  // The finished access moves to the output register once it is free or
  // being emptied in the same cycle.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = access.timing_valid ? S_CONV : S_DONE;
        end
      end
      S_CONV:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (!per_busy && !frq_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data_r      <= acc_r.read_data;
      timing_valid_r   <= acc_r.timing_valid;
      timing_channel_r <= acc_r.timing_channel;
      enabled_r        <= acc_r.channel_enabled;
      period_r         <= acc_r.timing_valid ? period_sat : '0;
      freq_r           <= acc_r.timing_valid ? freq_sat : '0;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.read_data       = read_data_r;
  assign out_bus.timing_valid    = timing_valid_r;
  assign out_bus.timing_channel  = timing_channel_r;
  assign out_bus.period_us       = period_r;
  assign out_bus.freq_millihertz = freq_r;
  assign out_bus.channel_enabled = enabled_r;

endmodule

`default_nettype wire

// ----- rtl/iti_checker.sv -----
// Port-level checker for the interval timer register interface, with its bind.
`default_nettype none

`include "interval_timer_register_interface_assert.svh"

module iti_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  read_data,
  input wire logic        timing_valid,
  input wire logic [1:0]  timing_channel,
  input wire logic [23:0] period_us,
  input wire logic [31:0] freq_millihertz,
  input wire logic        channel_enabled
);

  `ITI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(period_us) && $stable(freq_millihertz), "stalled result changed")

  `ITI_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer taken while an access is in work")

  `ITI_ASSERT_NOW(a_no_timing_zero, clk, rst_n, out_valid && !timing_valid, period_us == 24'd0 && freq_millihertz == 32'd0 && timing_channel == 2'd0, "timing fields set without a timing update")

  `ITI_ASSERT_NOW(a_timing_enabled, clk, rst_n, out_valid && timing_valid, channel_enabled, "timing update on a disabled channel")

  `ITI_ASSERT_NOW(a_write_no_data, clk, rst_n, out_valid && timing_valid, read_data == 8'd0 && freq_millihertz != 32'd0, "data write returned read data or zero frequency")

endmodule

bind interval_timer_register_interface iti_checker u_iti_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .read_data       (out_bus.read_data),
  .timing_valid    (out_bus.timing_valid),
  .timing_channel  (out_bus.timing_channel),
  .period_us       (out_bus.period_us),
  .freq_millihertz (out_bus.freq_millihertz),
  .channel_enabled (out_bus.channel_enabled)
);

`default_nettype wire

// ----- tb/interval_timer_register_interface_test.sv -----
// Self-checking testbench for the interval timer register interface: bus accesses in, one result each out.
`default_nettype none

module interval_timer_register_interface_test;
  import iti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default channel count and input clock. The
  // predictor below uses the same figures.
  localparam int unsigned TIMERS   = 3;
  localparam int unsigned CLOCK_HZ = 1193182;

  // The package names only the write request, so the read code is named here.
  localparam logic REQ_READ = 1'b0;

  // A data write on a timer with the default clock shows its result once both
  // dividers are done. The longest honest silence on both channels is the forced
  // receiver hold, so the watchdog limit sits well above that hold.
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 2500;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned RANDOM_ITEMS = 1650;

  // One expected result transfer, laid out field by field as on out_bus.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        timing_valid;
    logic [1:0]  timing_channel;
    logic [23:0] period_us;
    logic [31:0] freq_millihertz;
    logic        channel_enabled;
  } timer_result_t;

  // Register image of one timer channel as the bus sees it.
  typedef struct packed {
    logic [7:0] count_lo;
    logic [7:0] count_hi;
    logic [5:0] control;
    logic       bcd;
    logic       high_next;
    logic       alternate;
    logic       status_armed;
    logic       enabled;
  } timer_channel_t;

  logic clk;
  logic rst_n;

  iti_in_if  in_bus();
  iti_out_if out_bus();

  interval_timer_register_interface #(
    .NUM_TIMERS    (TIMERS),
    .INPUT_CLOCK_HZ(CLOCK_HZ)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Our own copy of the channel registers, advanced once per accepted access.
  timer_channel_t timer_regs [TIMERS];

  // Results that have been predicted but not yet seen on out_bus, oldest first.
  timer_result_t pending_results [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned idle_cycles;

  // When set, the sender offers items back to back with no gaps.
  bit sender_calm;
  // Set by a test to make the receiver drop ready for a long stretch.
  bit hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Prints one line for a failed check and counts it.
  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Command word that reprograms one channel.
  function automatic logic [7:0] program_cmd(logic [1:0] chan, logic [1:0] access,
                                             logic [2:0] mode, logic bcd);
    return {chan, access, mode, bcd};
  endfunction

  // Read-back command word. Both latch flags are active low, as on the part.
  function automatic logic [7:0] readback_cmd(logic no_count, logic no_status,
                                              logic [2:0] chans);
    return {CMD_READBACK, no_count, no_status, chans, 1'b0};
  endfunction

  // Applies one bus access to the register image and returns the result that
  // the block must produce for it.
  function automatic timer_result_t apply_bus_access(logic req, logic [1:0] port,
                                                     logic [7:0] data);
    timer_result_t res;
    logic [1:0] sel;
    logic [1:0] access;
    logic [15:0] raw;
    longint unsigned count;
    longint unsigned period;
    longint unsigned freq;
    logic [1:0] c;
    res = '0;
    if (port == PORT_CMD) begin
      if (req == REQ_WRITE) begin
        sel = data[7:6];
        access = data[5:4];
        if (sel == CMD_READBACK) begin
          // Status is armed for a selected channel only if the status flag
          // (active low) asks for it; unselected channels are disarmed.
          for (int n = 0; n < TIMERS; n++)
            timer_regs[n].status_armed = data[n + 1] && !data[4];
        end else if (sel < TIMERS && access != ACC_LATCH) begin
          timer_regs[sel] = '0;
          timer_regs[sel].control = data[5:0];
          timer_regs[sel].bcd = data[0];
          timer_regs[sel].high_next = (access == ACC_HIGH);
          timer_regs[sel].alternate = (access == ACC_BOTH);
        end
      end
    end else if (port < TIMERS) begin
      c = port;
      if (req == REQ_WRITE) begin
        if (timer_regs[c].high_next) timer_regs[c].count_hi = data;
        else timer_regs[c].count_lo = data;
        timer_regs[c].high_next ^= timer_regs[c].alternate;
        raw = {timer_regs[c].count_hi, timer_regs[c].count_lo};
        // In BCD mode nibbles above nine keep their face value as digits.
        if (timer_regs[c].bcd)
          count = 64'(raw[15:12]) * 1000 + 64'(raw[11:8]) * 100
                + 64'(raw[7:4]) * 10 + 64'(raw[3:0]);
        else
          count = 64'(raw);
        if (count == 0) count = timer_regs[c].bcd ? 64'd10000 : 64'd65536;
        period = count * 64'd1000000 / 64'(CLOCK_HZ);
        freq = 64'(CLOCK_HZ) * 64'd1000 / count;
        res.period_us = (period > 64'hFF_FFFF) ? 24'hFF_FFFF : period[23:0];
        res.freq_millihertz = (freq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : freq[31:0];
        timer_regs[c].enabled = 1'b1;
        res.timing_valid = 1'b1;
        res.timing_channel = port;
      end else if (timer_regs[c].status_armed) begin
        timer_regs[c].status_armed = 1'b0;
        res.read_data = {2'b00, timer_regs[c].control};
      end else begin
        res.read_data = timer_regs[c].high_next ? timer_regs[c].count_hi
                                                : timer_regs[c].count_lo;
        timer_regs[c].high_next ^= timer_regs[c].alternate;
      end
      res.channel_enabled = timer_regs[c].enabled;
    end
    return res;
  endfunction

  // Offers one access on in_bus and waits for its transfer. Valid is left high
  // on return, so the caller either sends again at once or calls release_bus.
  task automatic send_access(logic req, logic [1:0] port, logic [7:0] data);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.req_type <= req;
    in_bus.port <= port;
    in_bus.write_data <= data;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(apply_bus_access(req, port, data));
    items_sent++;
  endtask

  task automatic release_bus();
    in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_bus();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Out of reset: every data port reads zero and shows the channel disabled,
  // the command port reads zero, and a data write to a channel that was never
  // programmed lands in the low byte with a zero count meaning 65536.
  task automatic test_reset_state();
    send_access(REQ_READ, 2'd0, 8'hA5);
    send_access(REQ_READ, 2'd1, 8'h00);
    send_access(REQ_READ, 2'd2, 8'hFF);
    send_access(REQ_READ, PORT_CMD, 8'h00);
    send_access(REQ_WRITE, 2'd0, 8'h00);
  endtask

  // A latch command is ignored; high-byte-only and low-then-high access modes
  // steer writes and reads to the right byte.
  task automatic test_access_modes();
    send_access(REQ_WRITE, PORT_CMD, program_cmd(2'd1, ACC_LATCH, 3'd0, 1'b0));
    send_access(REQ_WRITE, PORT_CMD, program_cmd(2'd1, ACC_HIGH, 3'd7, 1'b0));
    send_access(REQ_WRITE, 2'd1, 8'hFF);
    send_access(REQ_READ, 2'd1, 8'h00);
    send_access(REQ_WRITE, PORT_CMD, program_cmd(2'd2, ACC_BOTH, 3'd3, 1'b0));
    // A count of one gives the highest frequency the block can report.
    send_access(REQ_WRITE, 2'd2, 8'h01);
    send_access(REQ_WRITE, 2'd2, 8'h00);
    send_access(REQ_READ, 2'd2, 8'h00);
    send_access(REQ_READ, 2'd2, 8'h00);
  endtask

  // BCD counts: zero stands for 10000, and nibbles above nine weigh as digits.
  task automatic test_bcd_counts();
    send_access(REQ_WRITE, PORT_CMD, program_cmd(2'd0, ACC_BOTH, 3'd2, 1'b1));
    send_access(REQ_WRITE, 2'd0, 8'h00);
    send_access(REQ_WRITE, 2'd0, 8'h00);
    send_access(REQ_WRITE, 2'd0, 8'hFF);
    send_access(REQ_WRITE, 2'd0, 8'hFF);
  endtask

  // Read-back arms status on all channels; the next read of each returns its
  // control bits. A read-back without the status flag disarms instead.
  task automatic test_status_readback();
    send_access(REQ_WRITE, PORT_CMD, readback_cmd(1'b1, 1'b0, 3'b111));
    send_access(REQ_READ, 2'd0, 8'h00);
    send_access(REQ_READ, 2'd1, 8'h00);
    send_access(REQ_READ, 2'd2, 8'h00);
    send_access(REQ_WRITE, PORT_CMD, readback_cmd(1'b0, 1'b0, 3'b010));
    send_access(REQ_WRITE, PORT_CMD, readback_cmd(1'b0, 1'b1, 3'b111));
    send_access(REQ_READ, 2'd0, 8'h00);
  endtask

  // The receiver holds ready low for a long stretch while the sender keeps
  // offering data writes, so the output register fills and in_bus stalls.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    sender_calm = 1'b1;
    repeat (12) send_access(REQ_WRITE, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
    sender_calm = 1'b0;
  endtask

  // The sender goes quiet until every outstanding result has come back, then
  // resumes, so the block sees a fully idle gap between accesses.
  task automatic test_sender_pause();
    wait_drained();
    send_access(REQ_WRITE, PORT_CMD, program_cmd(2'd1, ACC_BOTH, 3'd4, 1'b1));
    send_access(REQ_WRITE, 2'd1, 8'h99);
    send_access(REQ_WRITE, 2'd1, 8'h99);
    send_access(REQ_READ, 2'd1, 8'h00);
  endtask

  // Mostly well-formed programming sequences with random content: program a
  // channel, load bytes, sometimes arm status, then read back. The rest is
  // random accesses to any port.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned target;
    logic [1:0] chan;
    logic bcd;
    target = items_sent + n_items;
    while (items_sent < target) begin
      sender_calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) != 0) begin
        chan = 2'($urandom_range(0, 2));
        bcd = 1'($urandom_range(0, 1));
        send_access(REQ_WRITE, PORT_CMD,
                    program_cmd(chan, 2'($urandom_range(1, 3)), 3'($urandom_range(0, 7)), bcd));
        repeat ($urandom_range(1, 4)) begin
          if (bcd && $urandom_range(0, 1))
            send_access(REQ_WRITE, chan,
                        {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
          else
            send_access(REQ_WRITE, chan, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0) begin
          send_access(REQ_WRITE, PORT_CMD,
                      readback_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                                   3'($urandom_range(0, 7))));
          send_access(REQ_READ, chan, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) send_access(REQ_READ, chan, 8'($urandom_range(0, 255)));
      end else begin
        send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)));
      end
    end
    sender_calm = 1'b0;
  endtask

  // Receiver: alternates between calm stretches with ready always high and
  // stretches with random stalls. A hold request overrides both and keeps ready
  // low for the whole forced hold. Exactly one assignment to ready per clock edge.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned phase_left;
    bit calm;
    hold_left = 0;
    stall_left = 0;
    phase_left = 0;
    calm = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 4) == 0);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Result checker: every transfer on out_bus is matched against the oldest
  // prediction, field by field. Values are sampled as they stood before the
  // edge, so the outcome does not depend on event order within the step.
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no access outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_bus.read_data !== want.read_data)
          report_mismatch($sformatf("read_data got %h expected %h",
                                    out_bus.read_data, want.read_data));
        if (out_bus.timing_valid !== want.timing_valid)
          report_mismatch($sformatf("timing_valid got %b expected %b",
                                    out_bus.timing_valid, want.timing_valid));
        if (out_bus.timing_channel !== want.timing_channel)
          report_mismatch($sformatf("timing_channel got %h expected %h",
                                    out_bus.timing_channel, want.timing_channel));
        if (out_bus.period_us !== want.period_us)
          report_mismatch($sformatf("period_us got %0d expected %0d",
                                    out_bus.period_us, want.period_us));
        if (out_bus.freq_millihertz !== want.freq_millihertz)
          report_mismatch($sformatf("freq_millihertz got %0d expected %0d",
                                    out_bus.freq_millihertz, want.freq_millihertz));
        if (out_bus.channel_enabled !== want.channel_enabled)
          report_mismatch($sformatf("channel_enabled got %b expected %b",
                                    out_bus.channel_enabled, want.channel_enabled));
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main sequence: reset once, then the directed tests, the stall tests and
  // the random traffic, then drain and give the verdict.
  initial begin
    error_count = 0;
    items_sent = 0;
    idle_cycles = 0;
    sender_calm = 1'b0;
    hold_request = 1'b0;
    foreach (timer_regs[i]) timer_regs[i] = '0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_READ;
    in_bus.port = 2'd0;
    in_bus.write_data = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_access_modes();
    test_bcd_counts();
    test_status_readback();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic(RANDOM_ITEMS);

    // Let every outstanding result arrive, then watch a little longer for
    // anything extra the block might still emit.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/iti_pkg.sv
rtl/iti_ifs.sv
rtl/iti_regs.sv
rtl/iti_div.sv
rtl/interval_timer_register_interface.sv
rtl/iti_checker.sv
tb/interval_timer_register_interface_test.sv
